// ===== sv/afcs_pkg.sv =====
package afcs_pkg;

    // Frame layout: dummy, status, four code bytes (big-endian), checksum
    localparam logic [2:0] POS_IDLE       = 3'd0;
    localparam logic [2:0] POS_STATUS     = 3'd1;
    localparam logic [2:0] POS_CODE_FIRST = 3'd2;
    localparam logic [2:0] POS_CODE_LAST  = 3'd5;
    localparam logic [2:0] POS_CHECKSUM   = 3'd6;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 30;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECKSUM_SEED = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_VOLTAGE   = 1'b1;

    localparam logic [7:0]            SEED_RESET = 8'd155;
    localparam logic [CFG_DATA_W-1:0] REF_RESET  = 30'd250000000;

    // Product of 32-bit code and 31-bit non-negative reference
    localparam int unsigned PROD_W = 63;
    // Bias that turns the arithmetic shift by 31 into truncation toward zero
    localparam logic signed [PROD_W-1:0] ROUND_BIAS = 63'sh7FFF_FFFF;

    // Decoded frame handed from the parser to the scaler
    typedef struct packed {
        logic signed [31:0] code;
        logic [7:0]         status;
        logic               err;
        logic               status_valid;
    } t_frame_res;

endpackage

// ===== sv/afcs_in_if.sv =====
interface afcs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;
    logic       link_failed;

    modport source (output valid, output rx_byte, output frame_start, output link_failed,
                    input ready);
    modport sink   (input valid, input rx_byte, input frame_start, input link_failed,
                    output ready);
endinterface

// ===== sv/afcs_out_if.sv =====
interface afcs_out_if;
    logic               valid;
    logic               ready;
    logic signed [30:0] voltage;
    logic [7:0]         status_byte;
    logic               error_flag;
    logic               status_valid;

    modport source (output valid, output voltage, output status_byte, output error_flag,
                    output status_valid, input ready);
    modport sink   (input valid, input voltage, input status_byte, input error_flag,
                    input status_valid, output ready);
endinterface

// ===== sv/afcs_frame_parser.sv =====
module afcs_frame_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_take,
    input  logic [7:0]            i_rx_byte,
    input  logic                  i_frame_start,
    input  logic                  i_link_failed,
    input  logic [7:0]            i_seed,
    output logic                  o_emit,
    output afcs_pkg::t_frame_res  o_res
);
    import afcs_pkg::*;

    logic [2:0]  r_pos,    n_pos;
    logic [31:0] r_code,   n_code;
    logic [7:0]  r_sum,    n_sum;
    logic [7:0]  r_status, n_status;
    logic        r_failed, n_failed;

    logic        failed_now;
    logic [7:0]  expect_sum;
    logic        sum_ok;

    assign failed_now = r_failed | i_link_failed;
    assign expect_sum = r_sum + i_seed;
    assign sum_ok     = !failed_now && (i_rx_byte == expect_sum);

    // Emit on the checksum byte of an open frame
    assign o_emit = i_take && !i_frame_start && (r_pos == POS_CHECKSUM);

    // Build the decoded frame; errors zero the code
    always_comb begin
        o_res.code         = sum_ok ? $signed(r_code) : 32'sd0;
        o_res.status       = failed_now ? 8'd0 : r_status;
        o_res.err          = !sum_ok;
        o_res.status_valid = !failed_now;
    end

    // Advance the frame state on each accepted byte
    always_comb begin
        n_pos    = r_pos;
        n_code   = r_code;
        n_sum    = r_sum;
        n_status = r_status;
        n_failed = r_failed;
        if (i_take) begin
            if (i_frame_start) begin
                n_pos    = POS_STATUS;
                n_failed = i_link_failed;
                n_code   = 32'd0;
                n_sum    = 8'd0;
                n_status = 8'd0;
            end else if (r_pos == POS_IDLE || r_pos > POS_CHECKSUM) begin
                // drop stray bytes
                n_pos = POS_IDLE;
            end else begin
                n_failed = failed_now;
                n_pos    = r_pos + 3'd1;
                if (r_pos == POS_STATUS) begin
                    n_status = i_rx_byte;
                end else if (r_pos >= POS_CODE_FIRST && r_pos <= POS_CODE_LAST) begin
                    n_code = {r_code[23:0], i_rx_byte};
                    n_sum  = r_sum + i_rx_byte;
                end else begin
                    n_pos    = POS_IDLE;
                    n_failed = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= POS_IDLE;
            r_code   <= 32'd0;
            r_sum    <= 8'd0;
            r_status <= 8'd0;
            r_failed <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_code   <= n_code;
            r_sum    <= n_sum;
            r_status <= n_status;
            r_failed <= n_failed;
        end
    end

endmodule

// ===== sv/adc_frame_checksum_scaler_unit.sv =====
// A frame result is registered in r_s1, r_s2 and r_out before it shows on o_out.
// One byte per cycle unless o_out stalls; pipeline: frame parser, multiply, truncate.
// The 32x31 product register and the truncation add each take one stage.
// Reset (synchronous, active low) closes any open frame, empties the pipeline
// and loads checksum_seed = 155 and ref_voltage = 250000000.
module adc_frame_checksum_scaler_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [afcs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [afcs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    afcs_in_if.sink                            i_in,
    afcs_out_if.source                         o_out
);
    import afcs_pkg::*;

    logic [7:0]            r_seed;
    logic [CFG_DATA_W-1:0] r_ref;

    logic                  take;
    logic                  emit;
    t_frame_res            frame_res;

    logic                  s1_free, s2_free, s3_free;

    logic                  r_s1_valid;
    t_frame_res            r_s1;
    logic                  r_s2_valid;
    logic signed [PROD_W-1:0] r_s2_prod, n_s2_prod;
    logic [7:0]            r_s2_status;
    logic                  r_s2_err;
    logic                  r_s2_sval;
    logic signed [PROD_W-1:0] n_adj;

    logic                  r_out_valid;
    logic signed [30:0]    r_voltage;
    logic [7:0]            r_status;
    logic                  r_err;
    logic                  r_sval;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SEED_RESET;
            r_ref  <= REF_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CHECKSUM_SEED: r_seed <= i_cfg_data[7:0];
                CFG_REF_VOLTAGE:   r_ref  <= i_cfg_data;
                default:           r_ref  <= r_ref;
            endcase
        end
    end

    // Per-stage flow control
    assign s3_free    = !r_out_valid || o_out.ready;
    assign s2_free    = !r_s2_valid || s3_free;
    assign s1_free    = !r_s1_valid || s2_free;
    assign i_in.ready = s1_free;
    assign take       = i_in.valid && i_in.ready;

    afcs_frame_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_rx_byte     (i_in.rx_byte),
        .i_frame_start (i_in.frame_start),
        .i_link_failed (i_in.link_failed),
        .i_seed        (r_seed),
        .o_emit        (emit),
        .o_res         (frame_res)
    );

    // Scale: code times reference, then truncate the shift by 31 toward zero
    assign n_s2_prod = r_s1.code * $signed({1'b0, r_ref});
    assign n_adj     = r_s2_prod + (r_s2_prod[PROD_W-1] ? ROUND_BIAS : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free) r_s1_valid  <= take && emit;
            if (s2_free) r_s2_valid  <= r_s1_valid;
            if (s3_free) r_out_valid <= r_s2_valid;
        end
    end

    // Payload stages, no reset
    always_ff @(posedge i_clk) begin
        if (s1_free) begin
            r_s1 <= frame_res;
        end
        if (s2_free) begin
            r_s2_prod   <= n_s2_prod;
            r_s2_status <= r_s1.status;
            r_s2_err    <= r_s1.err;
            r_s2_sval   <= r_s1.status_valid;
        end
        if (s3_free) begin
            r_voltage <= n_adj[61:31];
            r_status  <= r_s2_status;
            r_err     <= r_s2_err;
            r_sval    <= r_s2_sval;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.voltage      = r_voltage;
    assign o_out.status_byte  = r_status;
    assign o_out.error_flag   = r_err;
    assign o_out.status_valid = r_sval;

`ifndef ASSERT_OFF
    // Input stalls only when every stage is full and the output is held
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_s1_valid && r_s2_valid && r_out_valid && !o_out.ready))
        else $error("input stalled with a free stage");

    // An errored frame carries a zero product
    a_err_zero_prod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_s2_err) |-> (r_s2_prod == '0))
        else $error("errored frame has nonzero product");

    // An errored result reports zero voltage
    a_err_zero_volt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.error_flag) |-> (o_out.voltage == 31'sd0))
        else $error("errored result has nonzero voltage");

    // Failed transfer: no status and error raised
    a_fail_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.status_valid) |-> (o_out.error_flag && o_out.status_byte == 8'd0))
        else $error("failed transfer result malformed");
`endif

endmodule

// ===== tb/sv/tb_adc_frame_checksum_scaler_unit.sv =====
`timescale 1ns / 1ps

module tb_adc_frame_checksum_scaler_unit;
    import afcs_pkg::*;

    localparam logic [7:0]            SEED_AT_RESET = 8'd155;
    localparam logic [CFG_DATA_W-1:0] REF_AT_RESET  = 30'd250000000;
    localparam logic [CFG_DATA_W-1:0] REF_FULL      = 30'h3FFF_FFFF;
    localparam logic [CFG_DATA_W-1:0] REF_TOP       = 30'd1000000000;
    localparam int                    SEG_ITEMS     = 285;
    localparam int                    NO_FAIL       = -1;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
        logic       link_failed;
    } rx_item_t;

    typedef struct packed {
        logic signed [30:0] voltage;
        logic [7:0]         status_byte;
        logic               error_flag;
        logic               status_valid;
    } reading_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    afcs_in_if  in_ch ();
    afcs_out_if out_ch ();

    adc_frame_checksum_scaler_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // Stimulus and scoreboard storage
    rx_item_t byte_queue[$];
    reading_t pending_readings[$];
    rx_item_t next_item;
    logic     byte_taken;
    int       src_idle_pct;
    int       sink_stall_pct;
    int       mismatch_cnt;
    int       readings_checked;
    int       error_readings;
    int       cfg_writes;
    int       items_queued;

    // Predictor copy of the decoder state and registers
    logic [2:0]            frame_pos    = POS_IDLE;
    logic [31:0]           frame_code   = '0;
    logic [7:0]            frame_sum    = '0;
    logic [7:0]            frame_status = '0;
    logic                  frame_bad    = 1'b0;
    logic [7:0]            seed_reg     = SEED_AT_RESET;
    logic [CFG_DATA_W-1:0] vref_reg     = REF_AT_RESET;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Advance the frame decoder by one byte; return 1 when a reading is produced
    function automatic bit decode_byte(input rx_item_t it, output reading_t rd);
        logic [7:0]     csum_want;
        longint signed  prod;
        longint signed  quot;
        rd = '0;
        if (it.frame_start) begin
            frame_pos    = POS_STATUS;
            frame_bad    = it.link_failed;
            frame_code   = '0;
            frame_sum    = '0;
            frame_status = '0;
            return 1'b0;
        end
        if (frame_pos == POS_IDLE || frame_pos > POS_CHECKSUM) begin
            frame_pos = POS_IDLE;
            return 1'b0;
        end
        frame_bad = frame_bad | it.link_failed;
        if (frame_pos == POS_STATUS) begin
            frame_status = it.rx_byte;
        end else if (frame_pos <= POS_CODE_LAST) begin
            frame_code = {frame_code[23:0], it.rx_byte};
            frame_sum  = frame_sum + it.rx_byte;
        end else begin
            csum_want       = frame_sum + seed_reg;
            rd.status_byte  = frame_status;
            rd.status_valid = 1'b1;
            if (frame_bad) begin
                // Transfer failure wins over the checksum
                rd.status_byte  = '0;
                rd.error_flag   = 1'b1;
                rd.status_valid = 1'b0;
            end else if (it.rx_byte != csum_want) begin
                rd.error_flag = 1'b1;
            end else begin
                prod       = longint'(signed'(frame_code)) * longint'(vref_reg);
                quot       = prod / (longint'(1) <<< 31);
                rd.voltage = quot[30:0];
            end
            frame_pos = POS_IDLE;
            frame_bad = 1'b0;
            return 1'b1;
        end
        frame_pos = frame_pos + 3'd1;
        return 1'b0;
    endfunction

    // Driver: present bytes and toggle the result-side ready
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid  <= 1'b0;
            out_ch.ready <= 1'b0;
        end else begin
            if (!in_ch.valid || byte_taken) begin
                if (byte_queue.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    next_item = byte_queue.pop_front();
                    in_ch.valid       <= 1'b1;
                    in_ch.rx_byte     <= next_item.rx_byte;
                    in_ch.frame_start <= next_item.frame_start;
                    in_ch.link_failed <= next_item.link_failed;
                end else begin
                    // Hold junk on the payload while idle
                    in_ch.valid       <= 1'b0;
                    in_ch.rx_byte     <= 8'($urandom);
                    in_ch.frame_start <= 1'($urandom);
                    in_ch.link_failed <= 1'($urandom);
                end
            end
            out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Monitor: track registers, predict readings, compare delivered ones
    always @(posedge i_clk) begin
        reading_t want_rd;
        reading_t got_rd;
        rx_item_t seen;
        if (!i_rst_n) begin
            byte_taken <= 1'b0;
        end else begin
            byte_taken <= in_ch.valid && in_ch.ready;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_CHECKSUM_SEED)
                    seed_reg = i_cfg_data[7:0];
                else if (i_cfg_idx == CFG_REF_VOLTAGE)
                    vref_reg = i_cfg_data;
            end
            if (out_ch.valid && out_ch.ready) begin
                got_rd = '{out_ch.voltage, out_ch.status_byte, out_ch.error_flag,
                           out_ch.status_valid};
                if (pending_readings.size() == 0) begin
                    $error("unexpected reading: voltage %0d status %0h err %0b sv %0b",
                           got_rd.voltage, got_rd.status_byte, got_rd.error_flag,
                           got_rd.status_valid);
                    mismatch_cnt++;
                end else begin
                    want_rd = pending_readings.pop_front();
                    readings_checked++;
                    if (want_rd.error_flag)
                        error_readings++;
                    if (got_rd.voltage !== want_rd.voltage) begin
                        $error("voltage: expected %0d, actual %0d",
                               want_rd.voltage, got_rd.voltage);
                        mismatch_cnt++;
                    end
                    if (got_rd.status_byte !== want_rd.status_byte) begin
                        $error("status_byte: expected %0h, actual %0h",
                               want_rd.status_byte, got_rd.status_byte);
                        mismatch_cnt++;
                    end
                    if (got_rd.error_flag !== want_rd.error_flag) begin
                        $error("error_flag: expected %0b, actual %0b",
                               want_rd.error_flag, got_rd.error_flag);
                        mismatch_cnt++;
                    end
                    if (got_rd.status_valid !== want_rd.status_valid) begin
                        $error("status_valid: expected %0b, actual %0b",
                               want_rd.status_valid, got_rd.status_valid);
                        mismatch_cnt++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                seen = '{in_ch.rx_byte, in_ch.frame_start, in_ch.link_failed};
                if (decode_byte(seen, want_rd))
                    pending_readings.push_back(want_rd);
            end
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_writes++;
    endtask

    task automatic push_byte(input logic [7:0] b, input logic start, input logic fail);
        byte_queue.push_back('{b, start, fail});
        items_queued++;
    endtask

    // Queue a frame, optionally cut short, with a bad checksum or a failed byte
    task automatic push_frame(input logic [7:0] status, input logic [31:0] code,
                              input bit bad_csum, input int fail_at, input int len);
        logic [7:0] csum;
        logic [7:0] b;
        csum = code[31:24] + code[23:16] + code[15:8] + code[7:0] + seed_reg;
        if (bad_csum)
            csum = csum ^ 8'($urandom_range(1, 255));
        for (int i = 0; i < len; i++) begin
            if (i == 0)
                b = 8'($urandom);
            else if (i == 1)
                b = status;
            else if (i <= 5)
                b = code[31 - 8 * (i - 2) -: 8];
            else
                b = csum;
            push_byte(b, i == 0, i == fail_at);
        end
    endtask

    task automatic push_random_frame();
        int         kind;
        logic [31:0] code;
        case ($urandom_range(9))
            0:       code = 32'h7FFF_FFFF;
            1:       code = 32'h8000_0000;
            2:       code = 32'h0000_0000;
            3:       code = 32'hFFFF_FFFF;
            default: code = $urandom;
        endcase
        kind = $urandom_range(99);
        if (kind < 68)
            push_frame(8'($urandom), code, 1'b0, NO_FAIL, 7);
        else if (kind < 80)
            push_frame(8'($urandom), code, 1'b1, NO_FAIL, 7);
        else if (kind < 88)
            push_frame(8'($urandom), code, 1'($urandom), $urandom_range(0, 6), 7);
        else if (kind < 95)
            push_frame(8'($urandom), code, 1'b0, NO_FAIL, $urandom_range(1, 6));
        else
            repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0, 1'($urandom));
    endtask

    // Wait for all bytes taken and all readings delivered, then let the pipe settle
    task automatic wait_drained();
        while (byte_queue.size() > 0 || in_ch.valid || pending_readings.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        logic [7:0]            seg_seed;
        logic [CFG_DATA_W-1:0] seg_ref;
        int                    seg_start;
        int                    guard;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = CFG_CHECKSUM_SEED;
        i_cfg_data        = '0;
        in_ch.valid       = 1'b0;
        in_ch.rx_byte     = '0;
        in_ch.frame_start = 1'b0;
        in_ch.link_failed = 1'b0;
        out_ch.ready      = 1'b0;
        src_idle_pct      = 21;
        sink_stall_pct    = 50;
        mismatch_cnt      = 0;
        readings_checked  = 0;
        error_readings    = 0;
        cfg_writes        = 0;
        items_queued      = 0;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames under the reset register values
        push_byte(8'hFF, 1'b0, 1'b1);                           // stray byte while idle
        push_frame(8'h00, 32'h7FFF_FFFF, 1'b0, NO_FAIL, 7);     // largest positive code
        push_frame(8'hA5, 32'h1234_5678, 1'b0, NO_FAIL, 4);     // restart mid-frame
        push_frame(8'h5A, 32'h8000_0000, 1'b0, 0, 7);           // failure flagged on start byte
        push_frame(8'hFF, 32'hFFFF_FFFF, 1'b1, NO_FAIL, 7);     // checksum mismatch
        push_byte(8'h00, 1'b0, 1'b0);                           // byte after frame close
        wait_drained();

        // Random segments: two register settings per idle mode
        for (int seg = 0; seg < 6; seg++) begin
            case (seg / 2)
                0:       begin src_idle_pct = 21; sink_stall_pct = 50; end
                1:       begin src_idle_pct = 50; sink_stall_pct = 21; end
                default: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            endcase
            case (seg)
                0:       begin seg_seed = 8'h00; seg_ref = REF_FULL; end
                1:       begin seg_seed = 8'hFF; seg_ref = '0; end
                2:       begin seg_seed = 8'($urandom); seg_ref = REF_TOP; end
                3:       begin seg_seed = 8'h80; seg_ref = 30'd1; end
                4:       begin
                    seg_seed = 8'($urandom);
                    seg_ref  = CFG_DATA_W'($urandom_range(0, REF_TOP));
                end
                default: begin seg_seed = SEED_AT_RESET; seg_ref = REF_AT_RESET; end
            endcase
            cfg_write(CFG_CHECKSUM_SEED, {22'($urandom), seg_seed});
            cfg_write(CFG_REF_VOLTAGE, seg_ref);
            seg_start = items_queued;
            while (items_queued - seg_start < SEG_ITEMS)
                push_random_frame();
            if (seg < 5)
                wait_drained();
        end

        // Final drain with a bound on the wait for late readings
        while (byte_queue.size() > 0 || in_ch.valid)
            @(posedge i_clk);
        guard = 0;
        while (pending_readings.size() > 0 && guard < 500) begin
            @(posedge i_clk);
            guard++;
        end
        while (pending_readings.size() > 0) begin
            void'(pending_readings.pop_front());
            $error("reading never delivered");
            mismatch_cnt++;
        end
        repeat (10) @(posedge i_clk);

        $display("Run: %0d bytes queued, %0d register writes, %0d readings checked",
                 items_queued, cfg_writes, readings_checked);
        $display("     (%0d of them flagged as errors)", error_readings);
        if (mismatch_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
